FILE: sv/psft_pkg.sv
package psft_pkg;

   // input beat
   typedef struct packed {
      logic [1:0]  op;
      logic [9:0]  topic;
      logic [15:0] client_tag;
      logic [7:0]  msg_priority;
      logic [15:0] payload_handle;
   } req_type;

   // result beat
   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [5:0]  subscriber_id;
      logic [7:0]  out_priority;
      logic [15:0] out_handle;
      logic        last;
   } rsp_type;

   typedef logic [1:0] code_type;

   localparam code_type OP_REGISTER  = 2'd0;
   localparam code_type OP_SUBSCRIBE = 2'd1;
   localparam code_type OP_CREATE    = 2'd2;
   localparam code_type OP_PUBLISH   = 2'd3;

   localparam code_type KIND_ID_ASSIGNED = 2'd0;
   localparam code_type KIND_CREATE_REPLY = 2'd1;
   localparam code_type KIND_DELIVERY    = 2'd2;
   localparam code_type KIND_SUB_ERROR   = 2'd3;

   localparam code_type STATUS_OK        = 2'd0;
   localparam code_type STATUS_EXISTS    = 2'd1;
   localparam code_type STATUS_FULL      = 2'd2;
   localparam code_type STATUS_UNKNOWN   = 2'd3;

   // topic field extended to cover the widest topic index
   localparam int TOPIC_EXT_W = 13;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REG,
      ST_SCAN,
      ST_SUB_END,
      ST_CREATE,
      ST_PUB_START,
      ST_PUB_FAN
   } state_type;

endpackage

FILE: sv/psft_ram.sv
module psft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/publish_subscribe_fanout_table.sv
// Publish/subscribe fan-out table.
// req_* channel (valid/ready) takes one beat per operation: register client,
// subscribe, create topic or publish. rsp_* channel (valid/ready) returns the
// result beats; last marks the final beat of an operation. Subscribe success
// and publish to an empty or out-of-range topic return no beat.
// One operation is in flight at a time; req_ready is high only in idle.
// Subscribe scans the client tags (one client tag RAM read per cycle,
// newest first, stops on a match); publish reads one subscriber list RAM
// entry per delivery beat, pipelined against the output register.
// The output register lets the next beat be formed as the previous one is
// taken; a stall on rsp_ready holds the walk in place with no beat lost.
// After reset the topic RAM (active flag and subscriber count) is swept to
// zero, one entry a cycle, with req_ready low until the sweep is done.
// Client tags and subscriber lists need no clearing; only written entries
// are ever read. Since only one operation runs, a RAM write always lands
// before the next read of the same entry.
module publish_subscribe_fanout_table #(
   parameter int MAX_CLIENTS    = 32,
   parameter int NUM_TOPICS     = 1024,
   parameter int SUBS_PER_TOPIC = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  psft_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output psft_pkg::rsp_type rsp_data
);

   localparam int CW     = $clog2(MAX_CLIENTS + 1);     // client count
   localparam int IW     = $clog2(MAX_CLIENTS);         // client index
   localparam int TW     = $clog2(NUM_TOPICS);          // topic index
   localparam int SW     = $clog2(SUBS_PER_TOPIC + 1);  // subscriber count
   localparam int LW     = (SUBS_PER_TOPIC > 1) ? $clog2(SUBS_PER_TOPIC) : 1;
   localparam int LDEPTH = NUM_TOPICS * (1 << LW);
   localparam int TMW    = SW + 1;                      // {active, count}
   localparam int XW     = psft_pkg::TOPIC_EXT_W;

   psft_pkg::state_type state_ff, state_in;
   psft_pkg::req_type   item_ff, item_in;
   psft_pkg::rsp_type   rsp_ff, rsp_in, rsp_new;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0] count_ff, count_in;
   logic [TW-1:0] clr_ff, clr_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          found_ff, found_in;
   logic [CW-1:0] id_ff, id_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [SW-1:0] n_ff, n_in;

   // RAM ports
   logic           c_wr_en, c_rd_en;
   logic [IW-1:0]  c_wr_addr, c_rd_addr;
   logic [15:0]    c_wr_data, c_rd_data;
   logic           t_wr_en, t_rd_en;
   logic [TW-1:0]  t_wr_addr, t_rd_addr;
   logic [TMW-1:0] t_wr_data, t_rd_data;
   logic           l_wr_en, l_rd_en;
   logic [TW+LW-1:0] l_wr_addr, l_rd_addr;
   logic [5:0]     l_wr_data, l_rd_data;

   logic          accept, emit, emit_ok;
   logic [XW-1:0] req_topic_ext, item_topic_ext;
   logic          req_topic_ok, item_topic_ok;
   logic [TW-1:0] req_tidx, tidx;
   logic          t_active;
   logic [SW-1:0] t_count;
   logic [CW-1:0] rem_m1, id_next;
   logic [7:0]    id_ext, new_id_ext;
   logic          scan_hit, scan_done;
   logic          sub_full, sub_err;
   logic          client_full;
   logic          fan_last;
   logic [SW-1:0] slot_p1;
   logic          clr_done;

   assign req_topic_ext  = XW'(req_data.topic);
   assign item_topic_ext = XW'(item_ff.topic);
   assign req_topic_ok   = req_topic_ext < XW'(NUM_TOPICS);
   assign item_topic_ok  = item_topic_ext < XW'(NUM_TOPICS);
   assign req_tidx       = req_topic_ext[TW-1:0];
   assign tidx           = item_topic_ext[TW-1:0];

   assign t_active = t_rd_data[SW];
   assign t_count  = t_rd_data[SW-1:0];

   assign req_ready = (state_ff == psft_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign emit_ok   = !rsp_valid_ff || rsp_ready;

   assign clr_done    = (clr_ff == TW'(NUM_TOPICS - 1));
   assign client_full = (count_ff >= CW'(MAX_CLIENTS));
   assign new_id_ext  = 8'(count_ff + CW'(1));

   // newest-first tag scan: one read issued, one compare, per cycle
   assign rem_m1    = rem_ff - CW'(1);
   assign scan_hit  = cmp_valid_ff && (c_rd_data == item_ff.client_tag);
   assign scan_done = scan_hit || (rem_ff == '0);
   assign id_next   = CW'(cmp_idx_ff) + CW'(1);
   assign id_ext    = 8'(id_ff);

   assign sub_full = (t_count >= SW'(SUBS_PER_TOPIC));
   assign sub_err  = !item_topic_ok || !found_ff || sub_full;

   assign slot_p1  = slot_ff + SW'(1);
   assign fan_last = (slot_p1 == n_ff);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psft_pkg::ST_CLEAR: begin
            if (clr_done) state_in = psft_pkg::ST_IDLE;
         end
         psft_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.op)
                  psft_pkg::OP_REGISTER:  state_in = psft_pkg::ST_REG;
                  psft_pkg::OP_SUBSCRIBE: state_in = psft_pkg::ST_SCAN;
                  psft_pkg::OP_CREATE:    state_in = psft_pkg::ST_CREATE;
                  default:                state_in = psft_pkg::ST_PUB_START;
               endcase
            end
         end
         psft_pkg::ST_REG, psft_pkg::ST_CREATE: begin
            if (emit_ok) state_in = psft_pkg::ST_IDLE;
         end
         psft_pkg::ST_SCAN: begin
            if (scan_done) state_in = psft_pkg::ST_SUB_END;
         end
         psft_pkg::ST_SUB_END: begin
            if (!sub_err || emit_ok) state_in = psft_pkg::ST_IDLE;
         end
         psft_pkg::ST_PUB_START: begin
            if (item_topic_ok && (t_count != '0)) state_in = psft_pkg::ST_PUB_FAN;
            else                                  state_in = psft_pkg::ST_IDLE;
         end
         psft_pkg::ST_PUB_FAN: begin
            if (emit_ok && fan_last) state_in = psft_pkg::ST_IDLE;
         end
         default: state_in = psft_pkg::ST_CLEAR;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      emit      = 1'b0;
      rsp_new   = '0;
      rsp_new.last = 1'b1;
      c_wr_en   = 1'b0;
      c_wr_addr = count_ff[IW-1:0];
      c_wr_data = item_ff.client_tag;
      c_rd_en   = 1'b0;
      c_rd_addr = rem_m1[IW-1:0];
      t_wr_en   = 1'b0;
      t_wr_addr = tidx;
      t_wr_data = {1'b1, t_count};
      t_rd_en   = 1'b0;
      t_rd_addr = req_tidx;
      l_wr_en   = 1'b0;
      l_wr_addr = {tidx, t_count[LW-1:0]};
      l_wr_data = id_ext[5:0];
      l_rd_en   = 1'b0;
      l_rd_addr = {tidx, LW'(0)};
      case (state_ff)
         psft_pkg::ST_CLEAR: begin
            t_wr_en   = 1'b1;
            t_wr_addr = clr_ff;
            t_wr_data = '0;
         end
         psft_pkg::ST_IDLE: begin
            t_rd_en = accept && req_topic_ok;
         end
         psft_pkg::ST_REG: begin
            if (emit_ok) begin
               emit         = 1'b1;
               rsp_new.kind = psft_pkg::KIND_ID_ASSIGNED;
               if (client_full) begin
                  rsp_new.status = psft_pkg::STATUS_FULL;
               end else begin
                  c_wr_en               = 1'b1;
                  rsp_new.status        = psft_pkg::STATUS_OK;
                  rsp_new.subscriber_id = new_id_ext[5:0];
               end
            end
         end
         psft_pkg::ST_SCAN: begin
            c_rd_en = !scan_done;
         end
         psft_pkg::ST_SUB_END: begin
            if (sub_err) begin
               if (emit_ok) begin
                  emit         = 1'b1;
                  rsp_new.kind = psft_pkg::KIND_SUB_ERROR;
                  if (!item_topic_ok) begin
                     rsp_new.status = psft_pkg::STATUS_FULL;
                  end else if (!found_ff) begin
                     rsp_new.status = psft_pkg::STATUS_UNKNOWN;
                  end else begin
                     rsp_new.status        = psft_pkg::STATUS_FULL;
                     rsp_new.subscriber_id = id_ext[5:0];
                  end
               end
            end else begin
               l_wr_en   = 1'b1;
               t_wr_en   = 1'b1;
               t_wr_data = {t_active, t_count + SW'(1)};
            end
         end
         psft_pkg::ST_CREATE: begin
            if (emit_ok) begin
               emit         = 1'b1;
               rsp_new.kind = psft_pkg::KIND_CREATE_REPLY;
               if (!item_topic_ok) begin
                  rsp_new.status = psft_pkg::STATUS_FULL;
               end else if (t_active) begin
                  rsp_new.status = psft_pkg::STATUS_EXISTS;
               end else begin
                  rsp_new.status = psft_pkg::STATUS_OK;
                  t_wr_en        = 1'b1;
               end
            end
         end
         psft_pkg::ST_PUB_START: begin
            if (item_topic_ok) begin
               t_wr_en = 1'b1;
               l_rd_en = (t_count != '0);
            end
         end
         psft_pkg::ST_PUB_FAN: begin
            if (emit_ok) begin
               emit                  = 1'b1;
               rsp_new.kind          = psft_pkg::KIND_DELIVERY;
               rsp_new.status        = psft_pkg::STATUS_OK;
               rsp_new.subscriber_id = l_rd_data;
               rsp_new.out_priority  = item_ff.msg_priority;
               rsp_new.out_handle    = item_ff.payload_handle;
               rsp_new.last          = fan_last;
               // fetch the next list entry while this beat goes out
               l_rd_en   = !fan_last;
               l_rd_addr = {tidx, slot_p1[LW-1:0]};
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath next
   always_comb begin
      item_in      = accept ? req_data : item_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      rem_in       = rem_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      id_in        = id_ff;
      slot_in      = slot_ff;
      n_in         = n_ff;
      rsp_in       = emit ? rsp_new : rsp_ff;
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);

      case (state_ff)
         psft_pkg::ST_CLEAR: begin
            clr_in = clr_ff + TW'(1);
         end
         psft_pkg::ST_IDLE: begin
            rem_in       = count_ff;
            cmp_valid_in = 1'b0;
         end
         psft_pkg::ST_REG: begin
            if (c_wr_en) count_in = count_ff + CW'(1);
         end
         psft_pkg::ST_SCAN: begin
            if (scan_done) begin
               found_in = scan_hit;
               id_in    = id_next;
            end else begin
               rem_in       = rem_m1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = rem_m1[IW-1:0];
            end
         end
         psft_pkg::ST_PUB_START: begin
            slot_in = '0;
            n_in    = t_count;
         end
         psft_pkg::ST_PUB_FAN: begin
            if (emit && !fan_last) slot_in = slot_p1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psft_pkg::ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      rem_ff     <= rem_in;
      cmp_idx_ff <= cmp_idx_in;
      found_ff   <= found_in;
      id_ff      <= id_in;
      slot_ff    <= slot_in;
      n_ff       <= n_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- memories
   psft_ram #(
      .WIDTH (16),
      .DEPTH (MAX_CLIENTS)
   ) u_client_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_en   (c_rd_en),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_data)
   );

   psft_ram #(
      .WIDTH (TMW),
      .DEPTH (NUM_TOPICS)
   ) u_topic_ram (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (t_wr_addr),
      .wr_data (t_wr_data),
      .rd_en   (t_rd_en),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd_data)
   );

   psft_ram #(
      .WIDTH (6),
      .DEPTH (LDEPTH)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (l_wr_en),
      .wr_addr (l_wr_addr),
      .wr_data (l_wr_data),
      .rd_en   (l_rd_en),
      .rd_addr (l_rd_addr),
      .rd_data (l_rd_data)
   );

endmodule

FILE: tb/tb_publish_subscribe_fanout_table.sv
module tb_publish_subscribe_fanout_table;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_CLIENTS    = 32;
   localparam int NUM_TOPICS     = 1024;
   localparam int SUBS_PER_TOPIC = 32;

   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 260;
   // stimulus left in the queue when idling stops for the rest of the run
   localparam int TAIL_ITEMS   = 30;
   // longest op is a full publish of 32 beats, so this leaves plenty of room
   localparam int DRAIN_CYCLES = 100;
   // slowest run: the topic RAM clear, then ~300 items each up to 32 beats
   // behind rsp_ready stalls; the limit is several times that
   localparam int LIMIT_CYCLES = 800000;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   psft_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   psft_pkg::rsp_type rsp_data;

   publish_subscribe_fanout_table #(
      .MAX_CLIENTS    (MAX_CLIENTS),
      .NUM_TOPICS     (NUM_TOPICS),
      .SUBS_PER_TOPIC (SUBS_PER_TOPIC)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Broker shadow state. Topic is 10 bits and NUM_TOPICS is 1024, so the
   // out-of-range topic paths cannot be reached from the port.
   // ------------------------------------------------------------------
   logic [15:0] tag_of_id   [MAX_CLIENTS];
   int          num_clients;
   bit          topic_live  [NUM_TOPICS];
   int          sub_count   [NUM_TOPICS];
   logic [5:0]  sub_list    [NUM_TOPICS][SUBS_PER_TOPIC];

   psft_pkg::rsp_type expected_beats[$];
   psft_pkg::req_type pending_items[$];

   int error_count = 0;
   int cycle_count = 0;
   bit req_fired   = 1'b0;
   bit calm        = 1'b0;
   int send_gap    = 0;
   int hold_gap    = 0;

   // generator-side view of registered tags, used to build valid subscribes
   logic [15:0] known_tags[$];
   logic [9:0]  hot_topics[6];

   initial begin
      num_clients = 0;
      foreach (topic_live[t]) begin
         topic_live[t] = 1'b0;
         sub_count[t]  = 0;
      end
   end

   // Apply one accepted request beat to the shadow state and queue the
   // response beats it should produce.
   task automatic broker_apply(input psft_pkg::req_type r);
      psft_pkg::rsp_type b;
      int      id;
      int      i;
      int      n;
      b      = '0;
      b.last = 1'b1;
      case (r.op)
         psft_pkg::OP_REGISTER: begin
            b.kind = psft_pkg::KIND_ID_ASSIGNED;
            if (num_clients >= MAX_CLIENTS) begin
               b.status = psft_pkg::STATUS_FULL;
            end else begin
               tag_of_id[num_clients] = r.client_tag;
               num_clients++;
               b.status        = psft_pkg::STATUS_OK;
               b.subscriber_id = 6'(num_clients);
            end
            expected_beats.push_back(b);
         end
         psft_pkg::OP_SUBSCRIBE: begin
            // duplicate tags: the newest id wins
            id = 0;
            for (i = 0; i < num_clients; i++)
               if (tag_of_id[i] == r.client_tag) id = i + 1;
            b.kind = psft_pkg::KIND_SUB_ERROR;
            if (id == 0) begin
               b.status = psft_pkg::STATUS_UNKNOWN;
               expected_beats.push_back(b);
            end else if (sub_count[r.topic] >= SUBS_PER_TOPIC) begin
               b.status        = psft_pkg::STATUS_FULL;
               b.subscriber_id = 6'(id);
               expected_beats.push_back(b);
            end else begin
               // success is silent
               sub_list[r.topic][sub_count[r.topic]] = 6'(id);
               sub_count[r.topic]++;
            end
         end
         psft_pkg::OP_CREATE: begin
            b.kind = psft_pkg::KIND_CREATE_REPLY;
            if (topic_live[r.topic]) begin
               b.status = psft_pkg::STATUS_EXISTS;
            end else begin
               topic_live[r.topic] = 1'b1;
               b.status = psft_pkg::STATUS_OK;
            end
            expected_beats.push_back(b);
         end
         default: begin
            // publish activates the topic even with nobody listening
            topic_live[r.topic] = 1'b1;
            n = sub_count[r.topic];
            for (i = 0; i < n; i++) begin
               b               = '0;
               b.kind          = psft_pkg::KIND_DELIVERY;
               b.status        = psft_pkg::STATUS_OK;
               b.subscriber_id = sub_list[r.topic][i];
               b.out_priority  = r.msg_priority;
               b.out_handle    = r.payload_handle;
               b.last          = (i + 1 == n);
               expected_beats.push_back(b);
            end
         end
      endcase
   endtask

   function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic add_item(input psft_pkg::code_type op, input logic [9:0] topic,
                           input logic [15:0] tag, input logic [7:0] prio,
                           input logic [15:0] handle);
      psft_pkg::req_type r;
      r.op             = op;
      r.topic          = topic;
      r.client_tag     = tag;
      r.msg_priority   = prio;
      r.payload_handle = handle;
      pending_items.push_back(r);
      if (op == psft_pkg::OP_REGISTER && known_tags.size() < MAX_CLIENTS)
         known_tags.push_back(tag);
   endtask

   function automatic logic [9:0] pick_topic();
      if ($urandom_range(0, 9) < 7) return hot_topics[$urandom_range(0, 5)];
      return 10'($urandom_range(0, NUM_TOPICS - 1));
   endfunction

   function automatic logic [15:0] pick_tag();
      if (known_tags.size() > 0 && $urandom_range(0, 99) < 85)
         return known_tags[$urandom_range(0, known_tags.size() - 1)];
      return 16'($urandom);
   endfunction

   // ------------------------------------------------------------------
   // Driver: request side changes on the falling edge. A beat stays up,
   // data frozen, until the rising edge that accepts it.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      logic              nv;
      psft_pkg::req_type nd;
      nv = req_valid;
      nd = req_data;
      if (!reset) begin
         if (req_valid && req_fired) nv = 1'b0;
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_items.size() > 0) begin
               if (!calm && pending_items.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(1, 14) - 1;
               end else begin
                  nd = pending_items.pop_front();
                  nv = 1'b1;
               end
            end
         end
      end
      req_valid <= nv;
      req_data  <= nd;
   end

   // Response side back-pressure, also on the falling edge; stalls land
   // whether or not a beat is waiting.
   always @(negedge clock) begin
      logic rdy;
      if (hold_gap > 0) begin
         hold_gap--;
         rdy = 1'b0;
      end else if (!calm && pending_items.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
         hold_gap = $urandom_range(1, 14) - 1;
         rdy = 1'b0;
      end else begin
         rdy = 1'b1;
      end
      rsp_ready <= rdy;
   end

   // ------------------------------------------------------------------
   // Monitor: everything sampled on the rising edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      psft_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected response beat %h", rsp_data);
            error_count++;
         end else begin
            want = expected_beats.pop_front();
            check_field("kind",          16'(want.kind),          16'(rsp_data.kind));
            check_field("status",        16'(want.status),        16'(rsp_data.status));
            check_field("subscriber_id", 16'(want.subscriber_id), 16'(rsp_data.subscriber_id));
            check_field("out_priority",  16'(want.out_priority),  16'(rsp_data.out_priority));
            check_field("out_handle",    want.out_handle,         rsp_data.out_handle);
            check_field("last",          16'(want.last),          16'(rsp_data.last));
         end
      end
      // predict after checking so a beat of the prior op is matched first
      req_fired = !reset && req_valid && req_ready;
      if (req_fired) broker_apply(req_data);
   end

   // Cycle counter, watchdog, and the calm windows with no idling at all.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 200 == 0) calm <= ($urandom_range(0, 3) == 0);
      if (cycle_count > LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus, reset and end of test
   // ------------------------------------------------------------------
   initial begin
      int rand_count;
      int floods;
      int k;
      int pick;

      hot_topics[0] = 10'd0;
      hot_topics[1] = 10'd1023;
      for (k = 2; k < 6; k++) hot_topics[k] = 10'($urandom_range(1, NUM_TOPICS - 2));

      // directed: empty table, tag extremes, duplicate tags, topic extremes
      add_item(psft_pkg::OP_SUBSCRIBE, 10'd5,    16'h0000, 8'h00, 16'h0000); // no clients yet
      add_item(psft_pkg::OP_REGISTER,  10'd0,    16'h0000, 8'h00, 16'h0000);
      add_item(psft_pkg::OP_REGISTER,  10'd1023, 16'hFFFF, 8'hFF, 16'hFFFF);
      add_item(psft_pkg::OP_REGISTER,  10'd0,    16'h5A5A, 8'h00, 16'h0000);
      add_item(psft_pkg::OP_REGISTER,  10'd0,    16'hFFFF, 8'h00, 16'h0000); // same tag
      add_item(psft_pkg::OP_PUBLISH,   10'd0,    16'h0000, 8'h80, 16'h1234); // nobody listening
      add_item(psft_pkg::OP_CREATE,    10'd0,    16'h0000, 8'h00, 16'h0000); // already active
      add_item(psft_pkg::OP_CREATE,    10'd1023, 16'h0000, 8'h00, 16'h0000);
      add_item(psft_pkg::OP_CREATE,    10'd1023, 16'h0000, 8'h00, 16'h0000);
      add_item(psft_pkg::OP_SUBSCRIBE, 10'd1023, 16'hFFFF, 8'h00, 16'h0000); // newest id wins
      add_item(psft_pkg::OP_SUBSCRIBE, 10'd1023, 16'h0000, 8'h00, 16'h0000);
      add_item(psft_pkg::OP_SUBSCRIBE, 10'd1023, 16'hFFFF, 8'h00, 16'h0000); // duplicate kept
      add_item(psft_pkg::OP_SUBSCRIBE, 10'd1023, 16'h5A5B, 8'h00, 16'h0000); // unknown tag
      add_item(psft_pkg::OP_PUBLISH,   10'd1023, 16'hFFFF, 8'hFF, 16'hFFFF);
      add_item(psft_pkg::OP_PUBLISH,   10'd1023, 16'h0000, 8'h00, 16'h0000);
      add_item(psft_pkg::OP_SUBSCRIBE, 10'h2AA,  16'h5A5A, 8'h00, 16'h0000); // topic not active
      add_item(psft_pkg::OP_PUBLISH,   10'h2AA,  16'h0000, 8'h55, 16'hA5A5);
      add_item(psft_pkg::OP_CREATE,    10'h2AA,  16'h0000, 8'h00, 16'h0000);
      add_item(psft_pkg::OP_CREATE,    10'h155,  16'h0000, 8'h00, 16'h0000);
      add_item(psft_pkg::OP_PUBLISH,   10'h155,  16'h0000, 8'h00, 16'h0000); // no subs

      // random part; a couple of floods push one topic past a full list and
      // then publish it for the maximum fan-out
      rand_count = 0;
      floods     = 0;
      while (rand_count < RANDOM_ITEMS) begin
         if (floods < 2 && rand_count > 40 && $urandom_range(0, 99) < 8) begin
            pick = pick_topic();
            for (k = 0; k < SUBS_PER_TOPIC + 2; k++)
               add_item(psft_pkg::OP_SUBSCRIBE, 10'(pick), pick_tag(), 8'($urandom),
                        16'($urandom));
            add_item(psft_pkg::OP_PUBLISH, 10'(pick), 16'($urandom), 8'($urandom),
                     16'($urandom));
            floods++;
            rand_count += SUBS_PER_TOPIC + 3;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
               add_item(psft_pkg::OP_REGISTER, 10'($urandom), 16'($urandom), 8'($urandom),
                        16'($urandom));
            else if (pick < 55)
               add_item(psft_pkg::OP_SUBSCRIBE, pick_topic(), pick_tag(), 8'($urandom),
                        16'($urandom));
            else if (pick < 70)
               add_item(psft_pkg::OP_CREATE, pick_topic(), 16'($urandom), 8'($urandom),
                        16'($urandom));
            else
               add_item(psft_pkg::OP_PUBLISH, pick_topic(), 16'($urandom), 8'($urandom),
                        16'($urandom));
            rand_count++;
         end
      end

      // single synchronous reset at the start
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain: all stimulus taken, every beat back, then a quiet window to
      // catch anything extra
      while (pending_items.size() > 0 || req_valid) @(posedge clock);
      while (expected_beats.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: publish_subscribe_fanout_table.f
sv/psft_pkg.sv
sv/psft_ram.sv
sv/publish_subscribe_fanout_table.sv
tb/tb_publish_subscribe_fanout_table.sv
